@@ rtl/nhn_pkg.sv @@
// ----------------------------------------------------------------------------
// nhn_pkg
// Shared types and constants for the Hamming number generator.
// ----------------------------------------------------------------------------
package nhn_pkg;

  // Width of the request index word
  localparam int unsigned INDEX_W = 12;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_RD3   = 7'b0000100,
    S_RD5   = 7'b0001000,
    S_CAP5  = 7'b0010000,
    S_MERGE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

endpackage

@@ rtl/nhn_ram.sv @@
// ----------------------------------------------------------------------------
// nhn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nhn_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/nth_hamming_number.sv @@
// ----------------------------------------------------------------------------
// nth_hamming_number
// Returns the n-th number whose only prime factors are 2, 3 and 5. The
// sequence is built in a RAM by the three-pointer merge, kept across
// requests and extended only as far as the highest index asked so far.
// Steps: check and output when the entry is already built; each new
//   entry adds check, RD3, RD5, CAP5 (three RAM reads on one port), merge.
// Requests: one word at a time; busy holds until the result is out.
// Reset: pointers and fill count return to entry one; the table restarts.
// The receiver cannot stall: done is a one-cycle strobe with value.
// ----------------------------------------------------------------------------
module nth_hamming_number #(
  parameter int unsigned MAX_INDEX   = 2048,
  parameter int unsigned VALUE_WIDTH = 40
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nhn_pkg::INDEX_W-1:0] index,
  output logic                        busy,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      value
);

  localparam int unsigned AW = (MAX_INDEX > 1) ? $clog2(MAX_INDEX) : 1;
  localparam int unsigned SW = nhn_pkg::INDEX_W + 1;
  localparam logic [VALUE_WIDTH-1:0] VMAX = '1;

  // Table positions are kept as addresses: address = position - 1
  nhn_pkg::state_t        state;
  logic [AW-1:0]          ptr_two;
  logic [AW-1:0]          ptr_three;
  logic [AW-1:0]          ptr_five;
  logic [AW-1:0]          last;
  logic [AW-1:0]          want;
  logic [VALUE_WIDTH-1:0] v2, v3, v5;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] rdata;
  logic                   rd_one;
  logic [VALUE_WIDTH-1:0] rd_val;

  logic [SW-1:0]          idx_sat;
  logic [AW-1:0]          want_next;

  logic [VALUE_WIDTH-1:0] c2, c3, c5, best;
  logic [VALUE_WIDTH+1:0] m3;
  logic [VALUE_WIDTH+2:0] m5;

  assign busy = (state != nhn_pkg::S_IDLE);

  // Clamp the request into 1..MAX_INDEX
  always_comb begin
    if (index == '0) begin
      idx_sat = SW'(1);
    end else if ({1'b0, index} > SW'(MAX_INDEX)) begin
      idx_sat = SW'(MAX_INDEX);
    end else begin
      idx_sat = {1'b0, index};
    end
    want_next = AW'(idx_sat - SW'(1));
  end

  // Table RAM; entry one is never written and reads back as 1
  nhn_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_INDEX)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    rd_one <= (raddr == '0);
  end

  assign rd_val = rd_one ? VALUE_WIDTH'(1) : rdata;

  // Read address per state
  always_comb begin
    unique case (state)
      nhn_pkg::S_CHECK: raddr = (last < want) ? ptr_two : want;
      nhn_pkg::S_RD3:   raddr = ptr_three;
      nhn_pkg::S_RD5:   raddr = ptr_five;
      default:          raddr = '0;
    endcase
  end

  // Saturating candidates: 2x by shift, 3x and 5x by shift-add
  always_comb begin
    m3 = {2'b00, v3} + {1'b0, v3, 1'b0};
    m5 = {3'b000, v5} + {1'b0, v5, 2'b00};
    c2 = v2[VALUE_WIDTH-1] ? VMAX : {v2[VALUE_WIDTH-2:0], 1'b0};
    c3 = (m3[VALUE_WIDTH+1:VALUE_WIDTH] != '0) ? VMAX : m3[VALUE_WIDTH-1:0];
    c5 = (m5[VALUE_WIDTH+2:VALUE_WIDTH] != '0) ? VMAX : m5[VALUE_WIDTH-1:0];
    best = (c2 < c3) ? c2 : c3;
    if (c5 < best) begin
      best = c5;
    end
  end

  assign we    = (state == nhn_pkg::S_MERGE);
  assign waddr = last + AW'(1);
  assign wdata = best;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nhn_pkg::S_IDLE;
      ptr_two   <= '0;
      ptr_three <= '0;
      ptr_five  <= '0;
      last      <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        nhn_pkg::S_IDLE: begin
          if (start) begin
            state <= nhn_pkg::S_CHECK;
          end
        end
        nhn_pkg::S_CHECK: begin
          state <= (last < want) ? nhn_pkg::S_RD3 : nhn_pkg::S_OUT;
        end
        nhn_pkg::S_RD3:   state <= nhn_pkg::S_RD5;
        nhn_pkg::S_RD5:   state <= nhn_pkg::S_CAP5;
        nhn_pkg::S_CAP5:  state <= nhn_pkg::S_MERGE;
        nhn_pkg::S_MERGE: begin
          if (c2 == best) begin
            ptr_two <= ptr_two + AW'(1);
          end
          if (c3 == best) begin
            ptr_three <= ptr_three + AW'(1);
          end
          if (c5 == best) begin
            ptr_five <= ptr_five + AW'(1);
          end
          last  <= last + AW'(1);
          state <= nhn_pkg::S_CHECK;
        end
        nhn_pkg::S_OUT: begin
          done  <= 1'b1;
          state <= nhn_pkg::S_IDLE;
        end
        default: state <= nhn_pkg::S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == nhn_pkg::S_IDLE && start) begin
      want <= want_next;
    end
    if (state == nhn_pkg::S_RD3) begin
      v2 <= rd_val;
    end
    if (state == nhn_pkg::S_RD5) begin
      v3 <= rd_val;
    end
    if (state == nhn_pkg::S_CAP5) begin
      v5 <= rd_val;
    end
    if (state == nhn_pkg::S_OUT) begin
      value <= rd_val;
    end
  end

`ifndef ASSERT_OFF
  // A result word only follows the output read
  a_done_after_out: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == nhn_pkg::S_OUT))
    else $error("done without output read");

  // Merge pointers never pass the last built entry
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (ptr_two <= last) && (ptr_three <= last) && (ptr_five <= last))
    else $error("merge pointer beyond table fill");

  // Entry one is fixed and never overwritten
  a_no_write_first: assert property (@(posedge clk) disable iff (rst)
    we |-> (waddr != '0))
    else $error("write to entry one");

  // An accepted request starts the fill check next cycle
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == nhn_pkg::S_CHECK))
    else $error("accepted word not processed");
`endif

endmodule
